[sv/sms_pkg.sv]
// ----------------------------------------------------------------------------
// Servo motion sequencer package
// Shared item types, field widths, result codes and the pulse conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package sms_pkg;

  localparam int SlotsDefault      = 10;
  localparam int MaxActionsDefault = 13;
  localparam int ChannelsDefault   = 16;

  localparam int ChanNum  = 16;   // channel field covers sixteen outputs
  localparam int PosW     = 4;
  localparam int FillW    = 5;
  localparam int OutLimit = 20;
  localparam int CntW     = 5;

  localparam int UNeutral = 150;  // microseconds divided by ten
  localparam int UMin     = 50;
  localparam int UMax     = 250;
  localparam int SpeedLim = 100;
  localparam int Recip    = 67109; // ceil(2^23 / 125)
  localparam logic [11:0] PulseNeutral = 12'(1500 * 128 / 625);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TICK  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    K_PWM   = 3'd0,
    K_DONE  = 3'd1,
    K_ADDED = 3'd2,
    K_ERROR = 3'd3,
    K_BUSY  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    E_TOO_MANY = 2'd0,
    E_NO_SLOT  = 2'd1,
    E_BAD_SLOT = 2'd2,
    E_EMPTY    = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_ST_CHK,
    S_ST_REL,
    S_SP_CHK,
    S_SP_EMIT,
    S_TK_SEL,
    S_TK_EVAL,
    S_TK_DONE,
    S_RUN,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  slot;
    logic [3:0]  channel;
    logic        direction;
    logic [7:0]  speed;
    logic [15:0] duration_ms;
    logic        last_action;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot_index;
    logic [3:0]  out_channel;
    logic [11:0] pulse_count;
    logic [1:0]  error_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] dur;
    logic [7:0]  speed;
    logic        dir;
    logic [3:0]  ch;
  } entry_t;

  // Pulse on-count: floor(us * 128 / 625) with us = 10 * u, so the count is
  // floor(u * 256 / 125), done as a reciprocal multiply.
  function automatic logic [11:0] pulse_of(logic dir, logic [7:0] spd);
    logic [8:0]  u;
    logic [16:0] x;
    logic [33:0] p;
    if (dir) begin
      u = (spd > 8'(SpeedLim)) ? 9'(UMax) : 9'(UNeutral) + {1'b0, spd};
    end else begin
      u = (spd >= 8'(SpeedLim)) ? 9'(UMin) : 9'(UNeutral) - {1'b0, spd};
    end
    x = {u[7:0], 8'b0} + {u[8], 16'b0};
    p = {17'b0, x} * 34'(Recip);
    return {1'b0, p[33:23]};
  endfunction

endpackage

`default_nettype wire

[sv/servo_motion_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// Servo motion sequencer
// Multi-slot timed servo sequencer driven by load, start, stop and tick items.
// ----------------------------------------------------------------------------
// The block takes one item at a time and is not ready until every result of
// that item has been handed to the output register. A small sequencer walks
// the work one step per cycle, stalling while the output register cannot
// take a result, and reads the action memory through a single registered
// port. A tick walks every slot in turn. Results go out one per cycle at
// most; the final one of an item carries last, and at most twenty results
// are given for one item. The action memory holds SLOTS*MAX_ACTIONS entries
// and needs no clearing after reset.
`default_nettype none

module servo_motion_sequencer_unit
  import sms_pkg::*;
#(
  parameter int SLOTS       = SlotsDefault,
  parameter int MAX_ACTIONS = MaxActionsDefault,
  parameter int CHANNELS    = ChannelsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int Depth  = SLOTS * MAX_ACTIONS;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SlotIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Sequencer and item registers.
  state_e    state_q, state_d;
  in_item_t  item_q, item_d;
  logic [3:0] s_q, s_d;
  logic      ret_tick_q, ret_tick_d;

  // Slot table.
  logic             active_q  [SLOTS];
  logic             active_d  [SLOTS];
  logic             running_q [SLOTS];
  logic             running_d [SLOTS];
  logic             waiting_q [SLOTS];
  logic             waiting_d [SLOTS];
  logic [PosW-1:0]  pos_q     [SLOTS];
  logic [PosW-1:0]  pos_d     [SLOTS];
  logic [PosW-1:0]  total_q   [SLOTS];
  logic [PosW-1:0]  total_d   [SLOTS];
  logic [31:0]      start_q   [SLOTS];
  logic [31:0]      start_d   [SLOTS];
  logic [ChanNum-1:0] busy_q, busy_d;
  logic [31:0]      now_q, now_d;

  // Load gathering.
  logic [FillW-1:0] fill_q, fill_d;
  logic [3:0]       lslot_q, lslot_d;
  logic             lhas_q, lhas_d;

  // Result path: one held-back result so that last can be set on the final one.
  logic      pend_valid_q, pend_valid_d;
  out_item_t pend_q, pend_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic [CntW-1:0] ecnt_q, ecnt_d;

  // Action memory.
  entry_t    mem [Depth];
  entry_t    mem_q;
  logic      rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  entry_t    wr_data;

  logic      emit_v;
  out_item_t emit_r;
  logic      can_emit;
  logic      fin_push;

  logic [SlotIW-1:0] sidx;
  logic      s_ok, last_slot;
  logic      free_any;
  logic [3:0] free_idx;
  logic [PosW-1:0] pos_inc;
  logic [3:0] ch_clamp;
  logic [FillW-1:0] fill_next;
  logic [3:0] ld_tgt;
  logic       ld_has;
  logic       expired;

  assign sidx      = s_q[SlotIW-1:0];
  assign s_ok      = ({1'b0, s_q} < 5'(SLOTS));
  assign last_slot = (s_q == 4'(SLOTS - 1));
  assign can_emit  = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign pos_inc   = pos_q[sidx] + PosW'(1);
  assign expired   = ((now_q - start_q[sidx]) >= {16'b0, mem_q.dur});

  // First slot that holds no sequence.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_any = 1'b1;
        free_idx = 4'(i);
      end
    end
  end

  assign ch_clamp  = ({1'b0, item_q.channel} >= 5'(CHANNELS)) ? 4'(CHANNELS - 1)
                                                               : item_q.channel;
  assign fill_next = (fill_q <= FillW'(MAX_ACTIONS)) ? fill_q + FillW'(1) : fill_q;
  assign ld_tgt    = (fill_q == '0) ? free_idx : lslot_q;
  assign ld_has    = (fill_q == '0) ? free_any : lhas_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_item_i.opcode)
            OP_LOAD:  state_d = S_LOAD;
            OP_START: state_d = S_ST_CHK;
            OP_STOP:  state_d = S_SP_CHK;
            default:  state_d = S_TK_SEL;
          endcase
        end
      end
      S_LOAD: begin
        if (can_emit) state_d = S_FIN;
      end
      S_ST_CHK: begin
        if (can_emit) begin
          if (!s_ok || total_q[sidx] == '0) state_d = S_FIN;
          else if (running_q[sidx] && !waiting_q[sidx]) state_d = S_ST_REL;
          else state_d = S_RUN;
        end
      end
      S_ST_REL: state_d = S_RUN;
      S_SP_CHK: begin
        if (!s_ok || !active_q[sidx]) state_d = S_FIN;
        else if (running_q[sidx] && !waiting_q[sidx]) state_d = S_SP_EMIT;
        else state_d = S_FIN;
      end
      S_SP_EMIT: begin
        if (can_emit) state_d = S_FIN;
      end
      S_TK_SEL: begin
        if (active_q[sidx] && running_q[sidx]) state_d = S_TK_EVAL;
        else if (last_slot) state_d = S_FIN;
      end
      S_TK_EVAL: begin
        if (can_emit) begin
          if (waiting_q[sidx]) state_d = S_RUN;
          else if (!expired) state_d = last_slot ? S_FIN : S_TK_SEL;
          else if (pos_inc < total_q[sidx]) state_d = S_RUN;
          else state_d = S_TK_DONE;
        end
      end
      S_TK_DONE, S_RUN: begin
        if (can_emit) begin
          if (state_q == S_RUN && !ret_tick_q) state_d = S_FIN;
          else state_d = last_slot ? S_FIN : S_TK_SEL;
        end
      end
      S_FIN: begin
        if (!pend_valid_q || can_emit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs of each step.
  always_comb begin
    item_d     = item_q;
    s_d        = s_q;
    ret_tick_d = ret_tick_q;
    active_d   = active_q;
    running_d  = running_q;
    waiting_d  = waiting_q;
    pos_d      = pos_q;
    total_d    = total_q;
    start_d    = start_q;
    busy_d     = busy_q;
    now_d      = now_q;
    fill_d     = fill_q;
    lslot_d    = lslot_q;
    lhas_d     = lhas_q;
    rd_en      = 1'b0;
    rd_addr    = AddrW'(sidx * MAX_ACTIONS + pos_q[sidx]);
    wr_en      = 1'b0;
    wr_addr    = AddrW'(ld_tgt * MAX_ACTIONS + fill_q);
    wr_data    = '{dur: item_q.duration_ms, speed: item_q.speed,
                   dir: item_q.direction, ch: ch_clamp};
    emit_v     = 1'b0;
    emit_r     = '0;
    fin_push   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_item_i;
          s_d    = in_item_i.slot;
          if (in_item_i.opcode == OP_TICK) begin
            now_d      = now_q + 32'd1;
            s_d        = '0;
            ret_tick_d = 1'b1;
          end else begin
            ret_tick_d = 1'b0;
          end
        end
      end
      S_LOAD: begin
        if (can_emit) begin
          lslot_d = ld_tgt;
          lhas_d  = ld_has;
          wr_en   = ld_has && (fill_q < FillW'(MAX_ACTIONS));
          fill_d  = fill_next;
          if (item_q.last_action) begin
            fill_d = '0;
            emit_v = 1'b1;
            if (fill_next > FillW'(MAX_ACTIONS)) begin
              emit_r.kind       = K_ERROR;
              emit_r.error_code = E_TOO_MANY;
            end else if (!ld_has) begin
              emit_r.kind       = K_ERROR;
              emit_r.error_code = E_NO_SLOT;
            end else begin
              total_d[ld_tgt[SlotIW-1:0]]   = fill_next[PosW-1:0];
              pos_d[ld_tgt[SlotIW-1:0]]     = '0;
              running_d[ld_tgt[SlotIW-1:0]] = 1'b0;
              waiting_d[ld_tgt[SlotIW-1:0]] = 1'b0;
              active_d[ld_tgt[SlotIW-1:0]]  = 1'b1;
              emit_r.kind       = K_ADDED;
              emit_r.slot_index = ld_tgt;
            end
          end
        end
      end
      S_ST_CHK: begin
        if (can_emit) begin
          if (!s_ok) begin
            emit_v            = 1'b1;
            emit_r.kind       = K_ERROR;
            emit_r.slot_index = s_q;
            emit_r.error_code = E_BAD_SLOT;
          end else if (total_q[sidx] == '0) begin
            emit_v            = 1'b1;
            emit_r.kind       = K_ERROR;
            emit_r.slot_index = s_q;
            emit_r.error_code = E_EMPTY;
          end else if (running_q[sidx] && !waiting_q[sidx]) begin
            rd_en = 1'b1;  // fetch the held channel so it can be released
          end else begin
            pos_d[sidx]     = '0;
            running_d[sidx] = 1'b1;
            waiting_d[sidx] = 1'b0;
            rd_en           = 1'b1;
            rd_addr         = AddrW'(sidx * MAX_ACTIONS);
          end
        end
      end
      S_ST_REL: begin
        busy_d[mem_q.ch] = 1'b0;
        pos_d[sidx]      = '0;
        running_d[sidx]  = 1'b1;
        waiting_d[sidx]  = 1'b0;
        rd_en            = 1'b1;
        rd_addr          = AddrW'(sidx * MAX_ACTIONS);
      end
      S_SP_CHK: begin
        if (s_ok && active_q[sidx]) begin
          if (running_q[sidx] && !waiting_q[sidx]) begin
            rd_en = 1'b1;
          end else begin
            running_d[sidx] = 1'b0;
            waiting_d[sidx] = 1'b0;
            pos_d[sidx]     = '0;
            active_d[sidx]  = 1'b0;
          end
        end
      end
      S_SP_EMIT: begin
        if (can_emit) begin
          emit_v             = 1'b1;
          emit_r.kind        = K_PWM;
          emit_r.slot_index  = s_q;
          emit_r.out_channel = mem_q.ch;
          emit_r.pulse_count = PulseNeutral;
          busy_d[mem_q.ch]   = 1'b0;
          running_d[sidx]    = 1'b0;
          waiting_d[sidx]    = 1'b0;
          pos_d[sidx]        = '0;
          active_d[sidx]     = 1'b0;
        end
      end
      S_TK_SEL: begin
        if (active_q[sidx] && running_q[sidx]) rd_en = 1'b1;
        else if (!last_slot) s_d = s_q + 4'd1;
      end
      S_TK_EVAL: begin
        if (can_emit) begin
          if (!waiting_q[sidx] && !expired) begin
            if (!last_slot) s_d = s_q + 4'd1;
          end else if (!waiting_q[sidx]) begin
            // Action ran out: neutral pulse, release, move on.
            emit_v             = 1'b1;
            emit_r.kind        = K_PWM;
            emit_r.slot_index  = s_q;
            emit_r.out_channel = mem_q.ch;
            emit_r.pulse_count = PulseNeutral;
            busy_d[mem_q.ch]   = 1'b0;
            pos_d[sidx]        = pos_inc;
            if (pos_inc < total_q[sidx]) begin
              rd_en   = 1'b1;
              rd_addr = AddrW'(sidx * MAX_ACTIONS + pos_inc);
            end else begin
              running_d[sidx] = 1'b0;
              waiting_d[sidx] = 1'b0;
              active_d[sidx]  = 1'b0;
              pos_d[sidx]     = '0;
            end
          end
        end
      end
      S_TK_DONE: begin
        if (can_emit) begin
          emit_v            = 1'b1;
          emit_r.kind       = K_DONE;
          emit_r.slot_index = s_q;
          if (!last_slot) s_d = s_q + 4'd1;
        end
      end
      S_RUN: begin
        if (can_emit) begin
          if (busy_q[mem_q.ch]) begin
            if (!waiting_q[sidx]) begin
              emit_v             = 1'b1;
              emit_r.kind        = K_BUSY;
              emit_r.slot_index  = s_q;
              emit_r.out_channel = mem_q.ch;
            end
            waiting_d[sidx] = 1'b1;
          end else begin
            busy_d[mem_q.ch]   = 1'b1;
            waiting_d[sidx]    = 1'b0;
            start_d[sidx]      = now_q;
            emit_v             = 1'b1;
            emit_r.kind        = K_PWM;
            emit_r.slot_index  = s_q;
            emit_r.out_channel = mem_q.ch;
            emit_r.pulse_count = pulse_of(mem_q.dir, mem_q.speed);
          end
          if (ret_tick_q && !last_slot) s_d = s_q + 4'd1;
        end
      end
      S_FIN: begin
        fin_push = pend_valid_q && can_emit;
      end
      default: ;
    endcase
  end

  // Result bookkeeping: a new result pushes the held one out with last low;
  // the end of the item pushes the held one with last high.
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    ecnt_d       = ecnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    if (emit_v && ecnt_q < CntW'(OutLimit)) begin
      ecnt_d       = ecnt_q + CntW'(1);
      pend_valid_d = 1'b1;
      pend_d       = emit_r;
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = pend_q;
      end
    end
    if (fin_push) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      out_d.last   = 1'b1;
      pend_valid_d = 1'b0;
    end
    if (state_q == S_FIN && state_d == S_IDLE) ecnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_tick_q   <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        active_q[i]  <= 1'b0;
        running_q[i] <= 1'b0;
        waiting_q[i] <= 1'b0;
        pos_q[i]     <= '0;
        total_q[i]   <= '0;
        start_q[i]   <= '0;
      end
      busy_q       <= '0;
      now_q        <= '0;
      fill_q       <= '0;
      lslot_q      <= '0;
      lhas_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      ecnt_q       <= '0;
    end else begin
      state_q      <= state_d;
      ret_tick_q   <= ret_tick_d;
      active_q     <= active_d;
      running_q    <= running_d;
      waiting_q    <= waiting_d;
      pos_q        <= pos_d;
      total_q      <= total_d;
      start_q      <= start_d;
      busy_q       <= busy_d;
      now_q        <= now_d;
      fill_q       <= fill_d;
      lslot_q      <= lslot_d;
      lhas_q       <= lhas_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      ecnt_q       <= ecnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    s_q    <= s_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(MAX_ACTIONS + 1))
    else $error("load fill count ran past its saturation value");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_valid_q && ecnt_q == '0)
    else $error("result held back while idle");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_v |-> can_emit)
    else $error("result produced with no room in the output register");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in work");

endmodule

`default_nettype wire
